// ===== sv/pddc_pkg.sv =====
`default_nettype none
package pddc_pkg;

  // fixed field widths
  localparam int DIST_W     = 16;
  localparam int GAIN_W     = 16;
  localparam int SPEED_W    = 7;
  localparam int CORR_W     = 8;
  localparam int TOL_W      = 16;
  localparam int DRIVE_W    = 8;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // unsaturated target fits 20 signed bits (|t| <= 335126)
  localparam int TGT_W = 20;

  // division by 11 as multiply by reciprocal, exact for magnitudes below 2^22
  localparam int MAG_W       = 22;
  localparam int RECIP_SHIFT = 25;
  localparam logic [MAG_W-1:0] RECIP_11 = 22'd3050403;

  // register reset values
  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 16'd51;
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST  = 16'd256;
  localparam logic [SPEED_W-1:0] MAX_FWD_RST     = 7'd80;
  localparam logic [SPEED_W-1:0] MAX_BWD_RST     = 7'd50;
  localparam logic [SPEED_W-1:0] MIN_SPEED_RST   = 7'd18;
  localparam logic [CORR_W-1:0]  MAX_CORR_RST    = 8'd50;
  localparam logic [TOL_W-1:0]   TOLERANCE_RST   = 16'd0;

  typedef enum logic [STATUS_W-1:0] {
    ST_RUNNING = 2'd0,
    ST_REACHED = 2'd1,
    ST_GAVE_UP = 2'd2,
    ST_IDLE    = 2'd3
  } status_t;

  typedef enum logic {
    KIND_START  = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN       = 3'd0,
    REG_DERIV_GAIN      = 3'd1,
    REG_MAX_SPEED_FWD   = 3'd2,
    REG_MAX_SPEED_BWD   = 3'd3,
    REG_MIN_SPEED       = 3'd4,
    REG_MAX_CORRECTIONS = 3'd5,
    REG_TOLERANCE       = 3'd6
  } cfg_reg_t;

endpackage
`default_nettype wire

// ===== sv/pddc_if.sv =====
`default_nettype none
// command channel: start or encoder sample
interface pddc_cmd_if #(parameter int COUNT_BITS = 24) ();
  import pddc_pkg::*;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic signed [DIST_W-1:0]     distance_qin;
  logic signed [COUNT_BITS-1:0] left_count;
  logic signed [COUNT_BITS-1:0] right_count;
  modport source (output valid, kind, distance_qin, left_count, right_count, input ready);
  modport sink   (input valid, kind, distance_qin, left_count, right_count, output ready);
endinterface

// response channel: drive command and status
interface pddc_rsp_if ();
  import pddc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;
  logic [STATUS_W-1:0]       status;
  modport source (output valid, drive, status, input ready);
  modport sink   (input valid, drive, status, output ready);
endinterface

// register write channel
interface pddc_cfg_if ();
  import pddc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/pd_drive_distance_controller.sv =====
`default_nettype none
// PD drive-distance controller. A start transaction converts a signed distance in quarter
// inches into a target in encoder counts and returns the first drive command; each sample
// transaction averages the two encoder counts, updates the error and returns a saturated
// drive from the Q8 proportional-plus-derivative sum, with a minimum-speed floor and a
// give-up limit. Every command transaction gives exactly one response transaction. One
// transaction is accepted per clock while the response is not stalled; it passes the input
// stage (target conversion or encoder average) and then the evaluation stage, in which both
// gain multiplies, the limit checks and the run state update happen together so that the
// next transaction sees the updated error. A stalled response holds the pipeline. Registers
// may be written whenever no transaction is in flight; the write port never stalls.
module pd_drive_distance_controller #(
  parameter int COUNT_BITS = 24
) (
  input  wire          clk,
  input  wire          rst,
  pddc_cfg_if.sink     cfg,
  pddc_cmd_if.sink     cmd,
  pddc_rsp_if.source   rsp
);
  import pddc_pkg::*;

  localparam int ERR_W  = COUNT_BITS + 1;
  localparam int DIF_W  = COUNT_BITS + 2;
  localparam int P1_W   = GAIN_W + 1 + ERR_W;
  localparam int P2_W   = GAIN_W + 1 + DIF_W;
  localparam int C_W    = P2_W + 1;
  localparam int WIDE_W = ((COUNT_BITS > TGT_W) ? COUNT_BITS : TGT_W) + 1;
  localparam logic signed [WIDE_W-1:0] CNT_MAX = WIDE_W'((64'sd1 <<< (COUNT_BITS - 1)) - 1);
  localparam logic signed [WIDE_W-1:0] CNT_MIN = -CNT_MAX - 1;

  // configuration registers
  logic [GAIN_W-1:0]  prop_gain;
  logic [GAIN_W-1:0]  deriv_gain;
  logic [SPEED_W-1:0] max_speed_forward;
  logic [SPEED_W-1:0] max_speed_backward;
  logic [SPEED_W-1:0] min_speed;
  logic [CORR_W-1:0]  max_corrections;
  logic [TOL_W-1:0]   tolerance;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain          <= PROP_GAIN_RST;
      deriv_gain         <= DERIV_GAIN_RST;
      max_speed_forward  <= MAX_FWD_RST;
      max_speed_backward <= MAX_BWD_RST;
      min_speed          <= MIN_SPEED_RST;
      max_corrections    <= MAX_CORR_RST;
      tolerance          <= TOLERANCE_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PROP_GAIN:       prop_gain          <= cfg.data;
        REG_DERIV_GAIN:      deriv_gain         <= cfg.data;
        REG_MAX_SPEED_FWD:   max_speed_forward  <= cfg.data[SPEED_W-1:0];
        REG_MAX_SPEED_BWD:   max_speed_backward <= cfg.data[SPEED_W-1:0];
        REG_MIN_SPEED:       min_speed          <= cfg.data[SPEED_W-1:0];
        REG_MAX_CORRECTIONS: max_corrections    <= cfg.data[CORR_W-1:0];
        REG_TOLERANCE:       tolerance          <= cfg.data;
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic s1_valid;
  logic advance;
  logic fire;

  assign advance   = !rsp.valid || rsp.ready;
  assign cmd.ready = !s1_valid || advance;
  assign fire      = s1_valid && advance;

  // target conversion: trunc((trunc(d*45/4)+1)*10/11)
  logic signed [21:0]       d45;
  logic signed [19:0]       q4;
  logic signed [23:0]       p10;
  logic                     p10_neg;
  logic [MAG_W-1:0]         p10_mag;
  logic [2*MAG_W-1:0]       div_prod;
  logic [TGT_W-2:0]         q11;
  logic signed [WIDE_W-1:0] t_wide;
  logic signed [WIDE_W-1:0] t_sat;

  always_comb begin
    d45      = 22'(cmd.distance_qin) * 22'sd45;
    q4       = 20'((d45 + (d45[21] ? 22'sd3 : 22'sd0)) >>> 2);
    p10      = 24'(q4 + 20'sd1) * 24'sd10;
    p10_neg  = p10[23];
    p10_mag  = MAG_W'(p10_neg ? -p10 : p10);
    div_prod = p10_mag * RECIP_11;
    q11      = div_prod[RECIP_SHIFT +: (TGT_W - 1)];
    t_wide   = p10_neg ? -WIDE_W'($signed({1'b0, q11})) : WIDE_W'($signed({1'b0, q11}));
    if (t_wide > CNT_MAX) begin
      t_sat = CNT_MAX;
    end else if (t_wide < CNT_MIN) begin
      t_sat = CNT_MIN;
    end else begin
      t_sat = t_wide;
    end
  end

  // encoder average truncated toward zero
  logic signed [COUNT_BITS:0] cnt_sum;
  logic signed [COUNT_BITS:0] cnt_half;

  always_comb begin
    cnt_sum  = (COUNT_BITS+1)'(cmd.left_count) + (COUNT_BITS+1)'(cmd.right_count);
    cnt_half = (cnt_sum + {{COUNT_BITS{1'b0}}, cnt_sum[COUNT_BITS]}) >>> 1;
  end

  // input stage
  logic                         s1_kind;
  logic signed [COUNT_BITS-1:0] s1_target;
  logic                         s1_backward;
  logic signed [COUNT_BITS-1:0] s1_avg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_kind     <= cmd.kind;
      s1_target   <= t_sat[COUNT_BITS-1:0];
      s1_backward <= cmd.distance_qin[DIST_W-1];
      s1_avg      <= cnt_half[COUNT_BITS-1:0];
    end
  end

  // run state
  logic signed [COUNT_BITS-1:0] target_counts;
  logic signed [ERR_W-1:0]      error_now;
  logic signed [ERR_W-1:0]      error_before;
  logic [CORR_W-1:0]            correction_count;
  logic                         running;
  logic                         going_backward;

  // evaluation stage
  logic                    is_start;
  logic                    active;
  logic signed [ERR_W-1:0] en_next;
  logic signed [ERR_W-1:0] eb_next;
  logic [ERR_W-1:0]        en_mag;
  logic [ERR_W-1:0]        eb_mag;
  logic signed [DIF_W-1:0] err_dif;
  logic signed [P1_W-1:0]  p_term;
  logic signed [P2_W-1:0]  d_term;
  logic signed [C_W-1:0]   cmd_q8;
  logic                    c_neg;
  logic [C_W-1:0]          c_mag;
  logic                    backward_next;
  logic [SPEED_W-1:0]      lim;
  logic [DRIVE_W-1:0]      lim8;
  logic [DRIVE_W-1:0]      lo8;
  logic                    within_tol;
  logic                    too_fast;
  logic                    too_slow;
  logic [CORR_W-1:0]       corr_next;
  logic                    running_next;
  logic [DRIVE_W-1:0]      drive_next;
  status_t                 status_next;

  always_comb begin
    is_start      = (s1_kind == KIND_START);
    active        = is_start || running;
    backward_next = is_start ? s1_backward : going_backward;
    if (is_start) begin
      en_next = ERR_W'(s1_target);
      eb_next = '0;
    end else begin
      en_next = ERR_W'(target_counts) - ERR_W'(s1_avg);
      eb_next = error_now;
    end
    en_mag     = en_next[ERR_W-1] ? -en_next : en_next;
    eb_mag     = eb_next[ERR_W-1] ? -eb_next : eb_next;
    within_tol = (en_mag <= ERR_W'(tolerance)) && (eb_mag <= ERR_W'(tolerance));
    err_dif    = DIF_W'(en_next) - DIF_W'(eb_next);
    p_term     = $signed({1'b0, prop_gain}) * en_next;
    d_term     = $signed({1'b0, deriv_gain}) * err_dif;
    cmd_q8     = C_W'(p_term) + C_W'(d_term);
    c_neg      = cmd_q8[C_W-1];
    c_mag      = c_neg ? -cmd_q8 : cmd_q8;
    lim        = backward_next ? max_speed_backward : max_speed_forward;
    lim8       = {1'b0, lim};
    lo8        = {1'b0, min_speed};
    too_fast   = c_mag > {{(C_W-SPEED_W-8){1'b0}}, lim, 8'd0};
    too_slow   = c_mag < {{(C_W-SPEED_W-8){1'b0}}, min_speed, 8'd0};

    corr_next    = is_start ? '0 : correction_count;
    running_next = active;
    drive_next   = '0;
    status_next  = ST_RUNNING;
    if (!active) begin
      status_next = ST_IDLE;
    end else if (within_tol) begin
      status_next  = ST_REACHED;
      running_next = 1'b0;
      corr_next    = '0;
    end else if (too_fast) begin
      drive_next = c_neg ? (8'd0 - lim8) : lim8;
    end else if (too_slow) begin
      if (corr_next < max_corrections) begin
        corr_next  = corr_next + 1'b1;
        drive_next = c_neg ? (8'd0 - lo8) : lo8;
      end else begin
        status_next  = ST_GAVE_UP;
        running_next = 1'b0;
        corr_next    = '0;
      end
    end else begin
      drive_next = c_neg ? (8'd0 - {1'b0, c_mag[14:8]}) : {1'b0, c_mag[14:8]};
    end
  end

  // state update with each evaluated start, or sample taken while running
  always_ff @(posedge clk) begin
    if (rst) begin
      target_counts    <= '0;
      error_now        <= '0;
      error_before     <= '0;
      correction_count <= '0;
      running          <= 1'b0;
      going_backward   <= 1'b0;
    end else if (fire && active) begin
      if (is_start) begin
        target_counts  <= s1_target;
        going_backward <= s1_backward;
      end
      error_now        <= en_next;
      error_before     <= eb_next;
      correction_count <= corr_next;
      running          <= running_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.drive  <= drive_next;
      rsp.status <= status_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/pddc_checker.sv =====
`default_nettype none
module pddc_checker (
  input wire                            clk,
  input wire                            rst,
  input wire                            cmd_valid,
  input wire                            cmd_ready,
  input wire                            rsp_valid,
  input wire                            rsp_ready,
  input wire [pddc_pkg::DRIVE_W-1:0]    rsp_drive,
  input wire [pddc_pkg::STATUS_W-1:0]   rsp_status
);
  import pddc_pkg::*;

  // a stalled response keeps its transaction
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive) && $stable(rsp_status))
    else $error("stalled response changed");

  // only a running response carries a drive
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != ST_RUNNING) |-> rsp_drive == '0)
    else $error("drive nonzero while not running");

  // drive stays within the symmetric 7-bit range
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_drive != 8'h80)
    else $error("drive out of range");

  // an accepted command has a response waiting once past the input stage and the response register
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |-> ##2 rsp_valid)
    else $error("response missing after command");

  // nothing left over after reset
  assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind pd_drive_distance_controller pddc_checker u_pddc_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_drive  (rsp.drive),
  .rsp_status (rsp.status)
);
`default_nettype wire
